// ===== design/mtds_pkg.sv =====
`timescale 1ns / 1ps

package mtds_pkg;

	// Core sizing
	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;

	localparam int TBL_N     = 1 << TABLE_ADDR_BITS;
	localparam int TAB_IDX_W = TABLE_ADDR_BITS + 1;
	localparam int TRIG_W    = SAMPLE_BITS;
	localparam int FB        = SAMPLE_BITS - 1;

	// Register and sample widths
	localparam int STEP_W    = 32;
	localparam int GAIN_W    = 12;
	localparam int OUT_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = STEP_W;

	// Datapath widths
	localparam int PROD_W = GAIN_W + 1 + TRIG_W;
	localparam int MM_W   = 2 * TRIG_W;
	localparam int MOD_W  = GAIN_W + 1 + MM_W;
	localparam int ACC_W  = GAIN_W + 5;

	// Accumulator channels, in issue order
	localparam int NUM_CH = 4;
	localparam int CH_W   = 2;
	localparam logic [CH_W-1:0] CH_SUB    = CH_W'(0);
	localparam logic [CH_W-1:0] CH_MAIN   = CH_W'(1);
	localparam logic [CH_W-1:0] CH_SECOND = CH_W'(2);
	localparam logic [CH_W-1:0] CH_THIRD  = CH_W'(3);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAIN_STEP      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_STEP    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_THIRD_STEP     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SUB_STEP       = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_MAIN_GAIN      = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_GAIN    = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_MODULATED_GAIN = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_THIRD_GAIN     = CFG_IDX_W'(7);

	// Register reset values
	localparam logic [STEP_W-1:0] RST_MAIN_STEP      = STEP_W'(435223419);
	localparam logic [STEP_W-1:0] RST_SECOND_STEP    = STEP_W'(1467447160);
	localparam logic [STEP_W-1:0] RST_THIRD_STEP     = STEP_W'(1460288881);
	localparam logic [STEP_W-1:0] RST_SUB_STEP       = STEP_W'(73229192);
	localparam logic [GAIN_W-1:0] RST_MAIN_GAIN      = GAIN_W'(1000);
	localparam logic [GAIN_W-1:0] RST_SECOND_GAIN    = GAIN_W'(640);
	localparam logic [GAIN_W-1:0] RST_MODULATED_GAIN = GAIN_W'(900);
	localparam logic [GAIN_W-1:0] RST_THIRD_GAIN     = GAIN_W'(900);

	// Table generation constants
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint          TRIG_MAX    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

	typedef logic [NUM_CH-1:0][STEP_W-1:0] step_arr_t;

	typedef struct packed {
		logic [GAIN_W-1:0] main;
		logic [GAIN_W-1:0] second;
		logic [GAIN_W-1:0] third;
		logic [GAIN_W-1:0] modulated;
	} gains_t;

	// Sequencer to phase unit
	typedef struct packed {
		logic            vld;
		logic            clr;
		logic            last;
		logic [CH_W-1:0] ch;
	} issue_t;

	typedef struct packed {
		logic            vld;
		logic            last;
		logic [CH_W-1:0] ch;
	} tag_t;

	// Phase unit to sine table
	typedef struct packed {
		tag_t                 tag;
		logic [TAB_IDX_W-1:0] sin_idx;
		logic [TAB_IDX_W-1:0] cos_idx;
		logic                 sin_neg;
		logic                 cos_neg;
	} trig_req_t;

	// Sine table to mixer
	typedef struct packed {
		tag_t               tag;
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} trig_t;

	// Quarter-wave entry: integer Taylor series in Q30, rounded to unsigned Q0.(SAMPLE_BITS-1)
	function automatic logic [SAMPLE_BITS-2:0] table_entry(input int k);
		longint unsigned x;
		longint unsigned term;
		longint          sum;
		longint          v;
		int              n;
		x = (HALF_PI_Q30 * longint'(k)) >> TABLE_ADDR_BITS;
		term = x;
		sum = longint'(x);
		for (n = 1; n <= 6; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			// divide by (2n)(2n+1)
			case (n)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				default: term = term / 64'd156;
			endcase
			if (n[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum * TRIG_MAX + (64'sd1 <<< 29)) >>> 30;
		if (v > TRIG_MAX) begin
			v = TRIG_MAX;
		end
		return v[SAMPLE_BITS-2:0];
	endfunction

	// Clamp the accumulated sum to the output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
		localparam logic signed [ACC_W-1:0] HI = ACC_W'((1 << (OUT_W - 1)) - 1);
		localparam logic signed [ACC_W-1:0] LO = -ACC_W'(1 << (OUT_W - 1));
		if (a > HI) begin
			return HI[OUT_W-1:0];
		end else if (a < LO) begin
			return LO[OUT_W-1:0];
		end
		return a[OUT_W-1:0];
	endfunction

endpackage

// ===== design/mtds_if.sv =====
`timescale 1ns / 1ps

// Sample tick channel
interface mtds_tick_if;
	logic valid;
	logic ready;
	logic phase_clear;

	modport source(output valid, output phase_clear, input ready);
	modport sink(input valid, input phase_clear, output ready);
endinterface

// Complex sample channel
interface mtds_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mtds_pkg::OUT_W-1:0]    in_phase;
	logic signed [mtds_pkg::OUT_W-1:0]    quadrature;

	modport source(output valid, output in_phase, output quadrature, input ready);
	modport sink(input valid, input in_phase, input quadrature, output ready);
endinterface

// Register write channel
interface mtds_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [mtds_pkg::CFG_IDX_W-1:0]      idx;
	logic [mtds_pkg::CFG_DAT_W-1:0]      wdata;

	modport source(output valid, output idx, output wdata, input ready);
	modport sink(input valid, input idx, input wdata, output ready);
endinterface

// ===== design/mtds_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read
module mtds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/mtds_phase_unit.sv =====
`timescale 1ns / 1ps

// Phase accumulators: read from memory, clear or advance, write back,
// and form the quarter-wave table addresses for sine and cosine.
module mtds_phase_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  mtds_pkg::issue_t    issue,
	input  mtds_pkg::step_arr_t steps,
	output mtds_pkg::trig_req_t req
);

	localparam int PB = mtds_pkg::PHASE_BITS;
	localparam int AB = mtds_pkg::TABLE_ADDR_BITS;
	localparam int IW = mtds_pkg::TAB_IDX_W;

	logic [mtds_pkg::NUM_CH-1:0] ent_vld_q;
	logic                        ent_ok_s1;
	mtds_pkg::issue_t            iss_s1;
	logic [PB-1:0]               rd_data;
	logic [PB-1:0]               phase_s1;
	logic [PB-1:0]               phase_nxt;
	logic [1:0]                  quad_sin;
	logic [1:0]                  quad_cos;
	logic [AB-1:0]               k;
	logic [IW-1:0]               k_ext;
	logic [IW-1:0]               k_mir;

	mtds_ram #(
		.WIDTH(PB),
		.DEPTH(mtds_pkg::NUM_CH)
	) u_phase_ram (
		.clk    (clk),
		.wr_en  (iss_s1.vld),
		.wr_addr(iss_s1.ch),
		.wr_data(phase_nxt),
		.rd_en  (issue.vld),
		.rd_addr(issue.ch),
		.rd_data(rd_data)
	);

	// Stage 1 control; entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1    <= '0;
			ent_ok_s1 <= 1'b0;
			ent_vld_q <= '0;
		end else begin
			iss_s1    <= issue;
			ent_ok_s1 <= ent_vld_q[issue.ch];
			if (iss_s1.vld) begin
				ent_vld_q[iss_s1.ch] <= 1'b1;
			end
		end
	end

	// Current phase and write-back value
	assign phase_s1  = (iss_s1.clr || !ent_ok_s1) ? '0 : rd_data;
	assign phase_nxt = phase_s1 + PB'(steps[iss_s1.ch]);

	// Quadrant fold; cosine is a quarter turn ahead
	assign quad_sin = phase_s1[PB-1 -: 2];
	assign quad_cos = quad_sin + 2'd1;
	assign k        = phase_s1[PB-3 -: AB];
	assign k_ext    = {1'b0, k};
	assign k_mir    = IW'(mtds_pkg::TBL_N) - k_ext;

	always_comb begin
		req.tag.vld  = iss_s1.vld;
		req.tag.last = iss_s1.last;
		req.tag.ch   = iss_s1.ch;
		req.sin_idx  = quad_sin[0] ? k_mir : k_ext;
		req.cos_idx  = quad_cos[0] ? k_mir : k_ext;
		req.sin_neg  = quad_sin[1];
		req.cos_neg  = quad_cos[1];
	end

endmodule

// ===== design/mtds_sine_rom.sv =====
`timescale 1ns / 1ps

// Quarter-wave sine table, two registered read ports, sign applied after
module mtds_sine_rom (
	input  logic                clk,
	input  logic                arst_n,
	input  mtds_pkg::trig_req_t req,
	output mtds_pkg::trig_t     trig
);

	localparam int TW = mtds_pkg::TRIG_W;

	logic [TW-2:0]     tab [mtds_pkg::TBL_N + 1];
	logic [TW-2:0]     sin_mag_s2;
	logic [TW-2:0]     cos_mag_s2;
	logic              sin_neg_s2;
	logic              cos_neg_s2;
	mtds_pkg::tag_t    tag_s2;
	logic signed [TW-1:0] sin_ext;
	logic signed [TW-1:0] cos_ext;

	// Table contents fixed at elaboration
	for (genvar gi = 0; gi <= mtds_pkg::TBL_N; gi++) begin : g_tab
		localparam logic [TW-2:0] ENTRY = mtds_pkg::table_entry(gi);
		assign tab[gi] = ENTRY;
	end

	// Registered reads
	always_ff @(posedge clk) begin
		sin_mag_s2 <= tab[req.sin_idx];
		cos_mag_s2 <= tab[req.cos_idx];
		sin_neg_s2 <= req.sin_neg;
		cos_neg_s2 <= req.cos_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= req.tag;
		end
	end

	assign sin_ext = $signed({1'b0, sin_mag_s2});
	assign cos_ext = $signed({1'b0, cos_mag_s2});

	always_comb begin
		trig.tag   = tag_s2;
		trig.sin_v = sin_neg_s2 ? -sin_ext : sin_ext;
		trig.cos_v = cos_neg_s2 ? -cos_ext : cos_ext;
	end

endmodule

// ===== design/mtds_mix.sv =====
`timescale 1ns / 1ps

// Gain multiply, subcarrier modulation, truncation and accumulation.
// The subcarrier goes first so its cosine is held for the main tone.
module mtds_mix (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  mtds_pkg::gains_t                       gains,
	input  mtds_pkg::trig_t                        trig,
	output logic                                   fin,
	output logic signed [mtds_pkg::ACC_W-1:0]      i_acc,
	output logic signed [mtds_pkg::ACC_W-1:0]      q_acc
);

	localparam int TW = mtds_pkg::TRIG_W;
	localparam int PW = mtds_pkg::PROD_W;
	localparam int MW = mtds_pkg::MM_W;
	localparam int DW = mtds_pkg::MOD_W;
	localparam int AW = mtds_pkg::ACC_W;
	localparam int FB = mtds_pkg::FB;
	localparam logic [PW-1:0] P_BIAS = PW'((1 << FB) - 1);
	localparam logic [DW-1:0] D_BIAS = (DW'(1) << (2 * FB)) - DW'(1);

	logic signed [TW-1:0]     subc_q;
	logic [mtds_pkg::GAIN_W-1:0] g_sel;
	logic signed [mtds_pkg::GAIN_W:0] g_s;
	logic signed [mtds_pkg::GAIN_W:0] gm_s;
	logic                     is_main;

	logic                     vld_s3, last_s3;
	logic signed [PW-1:0]     pc_s3, ps_s3;
	logic signed [MW-1:0]     mmc_s3, mms_s3;

	logic                     vld_s4, last_s4;
	logic signed [AW-1:0]     tc_s4, ts_s4;
	logic signed [DW-1:0]     modc_s4, mods_s4;

	logic signed [PW-1:0]     pc_b, ps_b;
	logic signed [DW-1:0]     modc_b, mods_b;
	logic signed [AW-1:0]     modc_t, mods_t;

	// Per-channel gain; the subcarrier has no direct term
	always_comb begin
		case (trig.tag.ch)
			mtds_pkg::CH_MAIN:   g_sel = gains.main;
			mtds_pkg::CH_SECOND: g_sel = gains.second;
			mtds_pkg::CH_THIRD:  g_sel = gains.third;
			default:             g_sel = '0;
		endcase
	end

	assign g_s     = $signed({1'b0, g_sel});
	assign gm_s    = $signed({1'b0, gains.modulated});
	assign is_main = (trig.tag.ch == mtds_pkg::CH_MAIN);

	// Stage 3: gain products and main times subcarrier
	always_ff @(posedge clk) begin
		pc_s3  <= PW'(g_s) * PW'(trig.cos_v);
		ps_s3  <= PW'(g_s) * PW'(trig.sin_v);
		mmc_s3 <= is_main ? MW'(trig.cos_v) * MW'(subc_q) : '0;
		mms_s3 <= is_main ? MW'(trig.sin_v) * MW'(subc_q) : '0;
		if (trig.tag.vld && trig.tag.ch == mtds_pkg::CH_SUB) begin
			subc_q <= trig.cos_v;
		end
	end

	// Truncate toward zero: bias negatives before the arithmetic shift
	assign pc_b = pc_s3 + (pc_s3[PW-1] ? P_BIAS : '0);
	assign ps_b = ps_s3 + (ps_s3[PW-1] ? P_BIAS : '0);

	// Stage 4: truncated direct terms and modulated products
	always_ff @(posedge clk) begin
		tc_s4   <= AW'(pc_b >>> FB);
		ts_s4   <= AW'(ps_b >>> FB);
		modc_s4 <= DW'(gm_s) * DW'(mmc_s3);
		mods_s4 <= DW'(gm_s) * DW'(mms_s3);
	end

	assign modc_b = modc_s4 + (modc_s4[DW-1] ? D_BIAS : '0);
	assign mods_b = mods_s4 + (mods_s4[DW-1] ? D_BIAS : '0);
	assign modc_t = AW'(modc_b >>> (2 * FB));
	assign mods_t = AW'(mods_b >>> (2 * FB));

	// Pipeline control and accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			last_s3 <= 1'b0;
			vld_s4  <= 1'b0;
			last_s4 <= 1'b0;
			fin     <= 1'b0;
			i_acc   <= '0;
			q_acc   <= '0;
		end else begin
			vld_s3  <= trig.tag.vld;
			last_s3 <= trig.tag.last;
			vld_s4  <= vld_s3;
			last_s4 <= last_s3;
			fin     <= vld_s4 && last_s4;
			if (start) begin
				i_acc <= '0;
				q_acc <= '0;
			end else if (vld_s4) begin
				i_acc <= i_acc + tc_s4 + modc_t;
				q_acc <= q_acc + ts_s4 + mods_t;
			end
		end
	end

endmodule

// ===== design/multi_tone_dds_sum.sv =====
`timescale 1ns / 1ps

// Four-tone direct digital synthesizer. Each accepted tick yields one complex
// sample taken at the current phases of the main, second, third and subcarrier
// accumulators (zeroed first when phase_clear is set), after which every phase
// advances by its step. The four phases live in a small RAM and are visited one
// per cycle; the sample is loaded into the output register once the last channel
// has left the pipeline, and the next tick is taken in the cycle after the sample
// is loaded, so no new tick is taken while one is in flight. A finished
// sample waits in the output register without holding off the next tick.
// Registers may be written at any time the block is idle; all eight registers
// return to their reset values on arst_n.
module multi_tone_dds_sum (
	input  logic          clk,
	input  logic          arst_n,
	mtds_tick_if.sink     tick,
	mtds_sample_if.source sample,
	mtds_cfg_if.sink      cfg
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0]                          st_q;
	logic [mtds_pkg::CH_W-1:0]           ch_q;
	logic                                clr_q;
	logic [mtds_pkg::STEP_W-1:0]         main_step_q, second_step_q, third_step_q, sub_step_q;
	mtds_pkg::gains_t                    gains_q;
	mtds_pkg::step_arr_t                 steps;
	mtds_pkg::issue_t                    issue;
	mtds_pkg::trig_req_t                 req;
	mtds_pkg::trig_t                     trig;
	logic                                start;
	logic                                fin;
	logic signed [mtds_pkg::ACC_W-1:0]   i_acc, q_acc;
	logic                                out_vld_q;
	logic signed [mtds_pkg::OUT_W-1:0]   i_q, q_q;
	logic                                out_free;
	logic                                load;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_step_q       <= mtds_pkg::RST_MAIN_STEP;
			second_step_q     <= mtds_pkg::RST_SECOND_STEP;
			third_step_q      <= mtds_pkg::RST_THIRD_STEP;
			sub_step_q        <= mtds_pkg::RST_SUB_STEP;
			gains_q.main      <= mtds_pkg::RST_MAIN_GAIN;
			gains_q.second    <= mtds_pkg::RST_SECOND_GAIN;
			gains_q.modulated <= mtds_pkg::RST_MODULATED_GAIN;
			gains_q.third     <= mtds_pkg::RST_THIRD_GAIN;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				mtds_pkg::REG_MAIN_STEP:      main_step_q   <= cfg.wdata;
				mtds_pkg::REG_SECOND_STEP:    second_step_q <= cfg.wdata;
				mtds_pkg::REG_THIRD_STEP:     third_step_q  <= cfg.wdata;
				mtds_pkg::REG_SUB_STEP:       sub_step_q    <= cfg.wdata;
				mtds_pkg::REG_MAIN_GAIN:
					gains_q.main <= cfg.wdata[mtds_pkg::GAIN_W-1:0];
				mtds_pkg::REG_SECOND_GAIN:
					gains_q.second <= cfg.wdata[mtds_pkg::GAIN_W-1:0];
				mtds_pkg::REG_MODULATED_GAIN:
					gains_q.modulated <= cfg.wdata[mtds_pkg::GAIN_W-1:0];
				mtds_pkg::REG_THIRD_GAIN:
					gains_q.third <= cfg.wdata[mtds_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Steps indexed by channel code
	always_comb begin
		steps                      = '0;
		steps[mtds_pkg::CH_MAIN]   = main_step_q;
		steps[mtds_pkg::CH_SECOND] = second_step_q;
		steps[mtds_pkg::CH_THIRD]  = third_step_q;
		steps[mtds_pkg::CH_SUB]    = sub_step_q;
	end

	assign tick.ready = (st_q == ST_IDLE);
	assign start      = tick.valid && tick.ready;
	assign out_free   = !out_vld_q || sample.ready;
	assign load       = out_free && ((st_q == ST_RUN && fin) || st_q == ST_HOLD);

	// Sequencer: one channel issued per cycle, then drain the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			ch_q  <= mtds_pkg::CH_SUB;
			clr_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (tick.valid) begin
						clr_q <= tick.phase_clear;
						ch_q  <= mtds_pkg::CH_SUB;
						st_q  <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					ch_q <= ch_q + mtds_pkg::CH_W'(1);
					if (ch_q == mtds_pkg::CH_THIRD) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (fin) begin
						st_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		issue.vld  = (st_q == ST_ISSUE);
		issue.clr  = clr_q;
		issue.last = (ch_q == mtds_pkg::CH_THIRD);
		issue.ch   = ch_q;
	end

	mtds_phase_unit u_phase (
		.clk   (clk),
		.arst_n(arst_n),
		.issue (issue),
		.steps (steps),
		.req   (req)
	);

	mtds_sine_rom u_rom (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.trig  (trig)
	);

	mtds_mix u_mix (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.gains (gains_q),
		.trig  (trig),
		.fin   (fin),
		.i_acc (i_acc),
		.q_acc (q_acc)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (sample.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			i_q <= mtds_pkg::sat_out(i_acc);
			q_q <= mtds_pkg::sat_out(q_acc);
		end
	end

	assign sample.valid      = out_vld_q;
	assign sample.in_phase   = i_q;
	assign sample.quadrature = q_q;

endmodule

// ===== design/mtds_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the synthesizer
module mtds_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              tick_valid,
	input logic                              tick_ready,
	input logic                              sample_valid,
	input logic                              sample_ready,
	input logic signed [mtds_pkg::OUT_W-1:0] in_phase,
	input logic signed [mtds_pkg::OUT_W-1:0] quadrature,
	input logic                              cfg_ready
);

	// A tick occupies the block through its channel issue cycles
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready ##1 !tick_ready ##1 !tick_ready)
		else $error("tick accepted while previous transaction in flight");

	// A new sample only appears while a tick is being processed
	a_sample_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid) |-> $past(!tick_ready))
		else $error("sample appeared without a transaction in flight");

	// A stalled sample stays offered
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid)
		else $error("sample dropped while stalled");

	// A stalled sample keeps its value
	a_sample_stable: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> $stable(in_phase) && $stable(quadrature))
		else $error("sample changed while stalled");

	// Register writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port not ready");

endmodule

bind multi_tone_dds_sum mtds_checker u_mtds_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tick_valid  (tick.valid),
	.tick_ready  (tick.ready),
	.sample_valid(sample.valid),
	.sample_ready(sample.ready),
	.in_phase    (sample.in_phase),
	.quadrature  (sample.quadrature),
	.cfg_ready   (cfg.ready)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int PHASE_BITS      = mtds_pkg::PHASE_BITS;
	localparam int TABLE_ADDR_BITS = mtds_pkg::TABLE_ADDR_BITS;
	localparam int TBL_N           = mtds_pkg::TBL_N;
	localparam int FB              = mtds_pkg::FB;
	localparam int OUT_W           = mtds_pkg::OUT_W;
	localparam int GAIN_W          = mtds_pkg::GAIN_W;
	localparam int CFG_IDX_W       = mtds_pkg::CFG_IDX_W;
	localparam int CFG_DAT_W       = mtds_pkg::CFG_DAT_W;

	localparam longint unsigned HALF_PI_RAD_Q30 = 64'd1686629713;
	localparam longint          FULL_SCALE      = (64'sd1 <<< FB) - 64'sd1;
	localparam longint          ONE_Q15         = 64'sd1 <<< FB;
	localparam longint          ONE_Q30         = 64'sd1 <<< (2 * FB);
	localparam logic [PHASE_BITS-1:0] QUARTER_TURN = {2'b01, {(PHASE_BITS-2){1'b0}}};
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;

	typedef struct {
		logic signed [OUT_W-1:0] i_s;
		logic signed [OUT_W-1:0] q_s;
	} iq_t;

	typedef enum {RX_FREE, RX_COIN, RX_EVERY3, RX_MOSTLY} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	mtds_tick_if   tick_ch();
	mtds_sample_if sample_ch();
	mtds_cfg_if    cfg_ch();

	multi_tone_dds_sum i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.sample (sample_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: register copy, phases, quarter-wave table
	logic [CFG_DAT_W-1:0]  reg_shadow [8];
	logic [PHASE_BITS-1:0] ph_main, ph_second, ph_third, ph_sub;
	int                    sine_rom [0:TBL_N];
	iq_t                   pending_samples [$];

	int  err_count = 0;
	int  sample_count = 0;
	bit  tick_offer = 1'b0;
	bit  cfg_offer = 1'b0;
	bit  stream_only = 1'b0;
	int  burst_left = 0;
	logic hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Quarter-wave entry, integer Taylor series in Q30
	function automatic int quarter_sine(input int k);
		longint unsigned x;
		longint unsigned term;
		longint          acc;
		longint          v;
		int              n;
		x = (HALF_PI_RAD_Q30 * longint'(k)) / longint'(TBL_N);
		term = x;
		acc = longint'(x);
		for (n = 1; n <= 6; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		v = (acc * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
		if (v > FULL_SCALE) begin
			v = FULL_SCALE;
		end
		return int'(v);
	endfunction

	function automatic longint sine_at(input logic [PHASE_BITS-1:0] ph);
		logic [1:0] quad;
		int         k;
		longint     v;
		quad = ph[PHASE_BITS-1 -: 2];
		k = int'(ph[PHASE_BITS-3 -: TABLE_ADDR_BITS]);
		v = quad[0] ? longint'(sine_rom[TBL_N - k]) : longint'(sine_rom[k]);
		return quad[1] ? -v : v;
	endfunction

	function automatic longint cos_at(input logic [PHASE_BITS-1:0] ph);
		return sine_at(ph + QUARTER_TURN);
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp16(input longint v);
		if (v > 32767) begin
			v = 32767;
		end else if (v < -32768) begin
			v = -32768;
		end
		return v[OUT_W-1:0];
	endfunction

	// Expected sample for one accepted tick, then advance all phases
	function automatic void predict_sample(input bit clr);
		longint mc, ms, sc, ss, tc, ts, subc;
		longint g_main, g_second, g_mod, g_third;
		longint i_acc, q_acc;
		iq_t    e;
		if (clr) begin
			ph_main = '0;
			ph_second = '0;
			ph_third = '0;
			ph_sub = '0;
		end
		mc = cos_at(ph_main);
		ms = sine_at(ph_main);
		sc = cos_at(ph_second);
		ss = sine_at(ph_second);
		tc = cos_at(ph_third);
		ts = sine_at(ph_third);
		subc = cos_at(ph_sub);
		g_main = longint'(reg_shadow[mtds_pkg::REG_MAIN_GAIN][GAIN_W-1:0]);
		g_second = longint'(reg_shadow[mtds_pkg::REG_SECOND_GAIN][GAIN_W-1:0]);
		g_mod = longint'(reg_shadow[mtds_pkg::REG_MODULATED_GAIN][GAIN_W-1:0]);
		g_third = longint'(reg_shadow[mtds_pkg::REG_THIRD_GAIN][GAIN_W-1:0]);
		// signed division truncates toward zero
		i_acc = (g_main * mc) / ONE_Q15 + (g_second * sc) / ONE_Q15
		      + (g_mod * (mc * subc)) / ONE_Q30 + (g_third * tc) / ONE_Q15;
		q_acc = (g_main * ms) / ONE_Q15 + (g_second * ss) / ONE_Q15
		      + (g_mod * (ms * subc)) / ONE_Q30 + (g_third * ts) / ONE_Q15;
		e.i_s = clamp16(i_acc);
		e.q_s = clamp16(q_acc);
		pending_samples.push_back(e);
		ph_main = ph_main + reg_shadow[mtds_pkg::REG_MAIN_STEP][PHASE_BITS-1:0];
		ph_second = ph_second + reg_shadow[mtds_pkg::REG_SECOND_STEP][PHASE_BITS-1:0];
		ph_third = ph_third + reg_shadow[mtds_pkg::REG_THIRD_STEP][PHASE_BITS-1:0];
		ph_sub = ph_sub + reg_shadow[mtds_pkg::REG_SUB_STEP][PHASE_BITS-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Output checker: one transaction against the oldest expected sample
	always @(posedge clk) begin
		iq_t e;
		if (arst_n === 1'b1 && sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample in_phase=%0d quadrature=%0d",
					sample_ch.in_phase, sample_ch.quadrature));
			end else begin
				e = pending_samples.pop_front();
				if (sample_ch.in_phase !== e.i_s) begin
					report_mismatch($sformatf("sample %0d in_phase got %0d want %0d",
						sample_count, sample_ch.in_phase, e.i_s));
				end
				if (sample_ch.quadrature !== e.q_s) begin
					report_mismatch($sformatf("sample %0d quadrature got %0d want %0d",
						sample_count, sample_ch.quadrature, e.q_s));
				end
			end
			sample_count++;
		end
	end

	// Receiver: stall pattern switching at random, plus an on-demand long hold-off
	always @(posedge clk) begin
		static rx_mode_e rx_mode = RX_FREE;
		static int mode_left = 0;
		static int hold_left = 0;
		static int rx_tick = 0;
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req <= 1'b0;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 150);
		end
		mode_left--;
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			sample_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: begin
					sample_ch.ready <= 1'b1;
				end
				RX_COIN: begin
					sample_ch.ready <= 1'($urandom_range(0, 1));
				end
				RX_EVERY3: begin
					sample_ch.ready <= (rx_tick % 3 == 0);
				end
				default: begin
					sample_ch.ready <= ($urandom_range(0, 7) != 0);
				end
			endcase
		end
	end

	// Offer one tick, wait for its transaction, then maybe pause between bursts
	task automatic send_tick(input bit clr);
		int gap;
		tick_ch.phase_clear <= clr;
		if (!tick_offer) begin
			tick_ch.valid <= 1'b1;
			tick_offer = 1'b1;
		end
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		predict_sample(clr);
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0 && !stream_only) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				tick_ch.valid <= 1'b0;
				tick_offer = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and let every expected sample come out
	task automatic drain();
		if (tick_offer) begin
			tick_ch.valid <= 1'b0;
			tick_offer = 1'b0;
		end
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_ch.idx <= idx;
		cfg_ch.wdata <= data;
		if (!cfg_offer) begin
			cfg_ch.valid <= 1'b1;
			cfg_offer = 1'b1;
		end
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		reg_shadow[idx] = (idx >= mtds_pkg::REG_MAIN_GAIN)
		                  ? (data & CFG_DAT_W'((1 << GAIN_W) - 1)) : data;
	endtask

	// Write all eight registers while idle, then release the write channel
	task automatic load_regs(input logic [CFG_DAT_W-1:0] vals [8]);
		int n;
		drain();
		for (n = 0; n < 8; n++) begin
			set_reg(CFG_IDX_W'(n), vals[n]);
		end
		cfg_ch.valid <= 1'b0;
		cfg_offer = 1'b0;
	endtask

	function automatic logic [CFG_DAT_W-1:0] pick_step();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return QUARTER_TURN * $urandom_range(0, 3);
			3: return $urandom_range(0, 32'h000F_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// Gains sometimes carry junk above bit 11, which the block must drop
	function automatic logic [CFG_DAT_W-1:0] pick_gain();
		logic [CFG_DAT_W-1:0] g;
		case ($urandom_range(0, 3))
			0: g = '0;
			1: g = (1 << GAIN_W) - 1;
			default: g = $urandom_range(0, (1 << GAIN_W) - 1);
		endcase
		if ($urandom_range(0, 2) == 0) begin
			g[CFG_DAT_W-1:GAIN_W] = (CFG_DAT_W - GAIN_W)'($urandom);
		end
		return g;
	endfunction

	task automatic test_reset_values();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// Quarter-turn steps, full gains: every quadrant boundary of the table
	task automatic test_quadrant_walk();
		logic [CFG_DAT_W-1:0] v [8];
		v = '{QUARTER_TURN, QUARTER_TURN, QUARTER_TURN, QUARTER_TURN,
		      32'hFFF, 32'hFFF, 32'hFFF, 32'hFFF};
		load_regs(v);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
	endtask

	// All-ones steps: each phase steps back by one and wraps past zero
	task automatic test_phase_wrap();
		logic [CFG_DAT_W-1:0] v [8];
		v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		      32'hFFF, 32'hFFF, 32'hFFF, 32'hFFF};
		load_regs(v);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
	endtask

	// Half-turn tones against a still subcarrier: most negative in-phase sum
	task automatic test_negative_extreme();
		logic [CFG_DAT_W-1:0] v [8];
		v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
		      32'hFFF, 32'hFFF, 32'hFFF, 32'hFFF};
		load_regs(v);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
	endtask

	// Junk above the gain width is masked; steps below table resolution
	task automatic test_gain_masking();
		logic [CFG_DAT_W-1:0] v [8];
		v = '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
		      32'hFFFF_F000, 32'hFFFF_F000, 32'hFFFF_F000, 32'hFFFF_F000};
		load_regs(v);
		send_tick(1'b0);
		send_tick(1'b1);
		v = '{32'h000F_FFFF, 32'h0000_0001, 32'h000F_FFFF, 32'h0000_0001,
		      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
		load_regs(v);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
	endtask

	// Several random register settings, each with a run of random ticks
	task automatic test_random_sweeps();
		logic [CFG_DAT_W-1:0] v [8];
		int sweep;
		int n;
		int clr_odds;
		for (sweep = 0; sweep < 7; sweep++) begin
			for (n = 0; n < 4; n++) begin
				v[n] = pick_step();
				v[n + 4] = pick_gain();
			end
			if (sweep == 0) begin
				for (n = 4; n < 8; n++) v[n] = 32'hFFF;
				for (n = 0; n < 4; n++) v[n] = $urandom;
			end
			load_regs(v);
			clr_odds = $urandom_range(4, 40);
			for (n = 0; n < 70; n++) begin
				send_tick($urandom_range(0, clr_odds - 1) == 0);
			end
		end
	endtask

	// Receiver holds off for a long stretch while ticks keep coming
	task automatic test_output_backpressure();
		logic [CFG_DAT_W-1:0] v [8];
		int n;
		for (n = 0; n < 4; n++) begin
			v[n] = $urandom;
			v[n + 4] = $urandom_range(0, (1 << GAIN_W) - 1);
		end
		load_regs(v);
		stream_only = 1'b1;
		hold_req <= 1'b1;
		for (n = 0; n < 40; n++) begin
			send_tick($urandom_range(0, 9) == 0);
		end
		stream_only = 1'b0;
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.phase_clear = 1'b0;
		sample_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.idx = '0;
		cfg_ch.wdata = '0;
		for (k = 0; k <= TBL_N; k++) begin
			sine_rom[k] = quarter_sine(k);
		end
		reg_shadow[mtds_pkg::REG_MAIN_STEP] = mtds_pkg::RST_MAIN_STEP;
		reg_shadow[mtds_pkg::REG_SECOND_STEP] = mtds_pkg::RST_SECOND_STEP;
		reg_shadow[mtds_pkg::REG_THIRD_STEP] = mtds_pkg::RST_THIRD_STEP;
		reg_shadow[mtds_pkg::REG_SUB_STEP] = mtds_pkg::RST_SUB_STEP;
		reg_shadow[mtds_pkg::REG_MAIN_GAIN] = CFG_DAT_W'(mtds_pkg::RST_MAIN_GAIN);
		reg_shadow[mtds_pkg::REG_SECOND_GAIN] = CFG_DAT_W'(mtds_pkg::RST_SECOND_GAIN);
		reg_shadow[mtds_pkg::REG_MODULATED_GAIN] = CFG_DAT_W'(mtds_pkg::RST_MODULATED_GAIN);
		reg_shadow[mtds_pkg::REG_THIRD_GAIN] = CFG_DAT_W'(mtds_pkg::RST_THIRD_GAIN);
		ph_main = '0;
		ph_second = '0;
		ph_third = '0;
		ph_sub = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_quadrant_walk();
		test_phase_wrap();
		test_negative_extreme();
		test_gain_masking();
		test_random_sweeps();
		test_output_backpressure();
		drain();

		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mtds_pkg.sv
design/mtds_if.sv
design/mtds_ram.sv
design/mtds_phase_unit.sv
design/mtds_sine_rom.sv
design/mtds_mix.sv
design/multi_tone_dds_sum.sv
design/mtds_checker.sv
tb/testbench.sv
